### rtl/tkc_pkg.sv
// ----------------------------------------------------------------------------
// tkc_pkg
// shared widths, codes and defaults of the top-k neighbor cache
// ----------------------------------------------------------------------------
`default_nettype none

package tkc_pkg;

   // default sizes
   localparam int NUM_OWNED_DEF   = 32;
   localparam int MAX_ENTRIES_DEF = 8;
   localparam int NODE_BITS_DEF   = 16;

   // field widths
   localparam int FUNC_W   = 2;
   localparam int INDEX_W  = 16;
   localparam int METRIC_W = 32;
   localparam int KIND_W   = 2;
   localparam int COUNT_W  = 6;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSIZE_W  = 4;

   // request functions
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_PRUNE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_BEST   = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

   // response kinds
   localparam logic [KIND_W-1:0] KIND_EMPTIED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DONE    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BEST    = 2'd2;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_METRIC_MODE    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CACHE_SIZE     = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_INDEX    = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INVALID_METRIC = 4'd3;

   // csr reset values
   localparam logic                      METRIC_MODE_RST    = 1'b0;
   localparam logic [CSIZE_W-1:0]        CACHE_SIZE_RST     = 4'd8;
   localparam logic [INDEX_W-1:0]        START_INDEX_RST    = 16'd0;
   localparam logic signed [METRIC_W-1:0] INVALID_METRIC_RST = -32'sd65536;

   // no-entry marker for source and dest
   localparam logic [INDEX_W-1:0] NO_INDEX = '1;

endpackage

`default_nettype wire

### rtl/tkc_if.sv
// ----------------------------------------------------------------------------
// tkc channel interfaces
// request, response and csr write channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface tkc_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [tkc_pkg::FUNC_W-1:0]             func;
   logic [tkc_pkg::INDEX_W-1:0]            owner_index;
   logic [tkc_pkg::INDEX_W-1:0]            node_index;
   logic signed [tkc_pkg::METRIC_W-1:0]    metric_in;
   modport source (output valid, func, owner_index, node_index, metric_in, input ready);
   modport sink   (input valid, func, owner_index, node_index, metric_in, output ready);
endinterface

interface tkc_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [tkc_pkg::KIND_W-1:0]             kind;
   logic [tkc_pkg::INDEX_W-1:0]            list_index;
   logic [tkc_pkg::COUNT_W-1:0]            emptied_count;
   logic                                   found;
   logic [tkc_pkg::INDEX_W-1:0]            source_index;
   logic [tkc_pkg::INDEX_W-1:0]            dest_index;
   logic signed [tkc_pkg::METRIC_W-1:0]    metric_out;
   logic                                   last;
   modport source (output valid, kind, list_index, emptied_count, found, source_index,
                   dest_index, metric_out, last, input ready);
   modport sink   (input valid, kind, list_index, emptied_count, found, source_index,
                   dest_index, metric_out, last, output ready);
endinterface

interface tkc_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [tkc_pkg::CSR_IDX_W-1:0]          index;
   logic [tkc_pkg::CSR_DATA_W-1:0]         data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/tkc_ram.sv
// ----------------------------------------------------------------------------
// tkc_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module tkc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/tkc_better.sv
// ----------------------------------------------------------------------------
// tkc_better
// shared metric compare unit, strict better in either direction
// ----------------------------------------------------------------------------
`default_nettype none

module tkc_better (
   input  wire logic                                mode,
   input  wire logic signed [tkc_pkg::METRIC_W-1:0] a,
   input  wire logic signed [tkc_pkg::METRIC_W-1:0] b,
   output logic                                     a_better
);

   // mode 1 is distance, smaller wins
   assign a_better = mode ? (a < b) : (a > b);

endmodule

`default_nettype wire

### rtl/topk_neighbor_cache_for_mst.sv
// ----------------------------------------------------------------------------
// topk_neighbor_cache_for_mst
// per-vertex best-first candidate cache with insert, prune and best query
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake         transaction
//  req_ch    in         valid / ready     one insert, prune or best query
//  rsp_ch    out        valid / ready     one emptied report, done or best entry
//  csr_ch    in         valid / ready     one register write, always ready
//
//  insert: range and capacity checks, a worst-entry check on a full list, a read
//   and a compare per scanned list entry, a decide step, a read and a write per
//   shifted entry and one final write; prune: a step per list, then per non-empty
//   list a read and a keep-or-drop step per stored entry, a length write, a report
//   if it emptied, and a done report at the end; best query: a step per list plus
//   a compare per non-empty list head, plus the report
//  every entry access goes through the single entry ram, whose read is
//   registered; req_ch is ready only while the sequencer is idle
//  reset (synchronous) clears list lengths, state and rsp valid and restores the csrs, the ram is not cleared
//  a stalled rsp_ch holds the sequencer at its next report
//
// ----------------------------------------------------------------------------
`default_nettype none

module topk_neighbor_cache_for_mst #(
   parameter int NUM_OWNED   = tkc_pkg::NUM_OWNED_DEF,
   parameter int MAX_ENTRIES = tkc_pkg::MAX_ENTRIES_DEF,
   parameter int NODE_BITS   = tkc_pkg::NODE_BITS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   tkc_req_if.sink   req_ch,
   tkc_rsp_if.source rsp_ch,
   tkc_csr_if.sink   csr_ch
);

   // sizes of counters and addresses
   localparam int LIST_BITS = (NUM_OWNED > 1) ? $clog2(NUM_OWNED) : 1;
   localparam int SLOT_BITS = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int LI_W      = $clog2(NUM_OWNED + 1);
   localparam int LEN_W     = $clog2(MAX_ENTRIES + 1);
   localparam int ADDR_W    = LIST_BITS + SLOT_BITS;
   localparam int DEPTH     = 1 << ADDR_W;
   localparam int MW        = tkc_pkg::METRIC_W;
   localparam int ENTRY_W   = NODE_BITS + MW;

   // sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_I_CHK  = 4'd1;   // insert: range and capacity checks
   localparam logic [3:0] S_I_CHKW = 4'd2;   // insert: full list, check worst entry
   localparam logic [3:0] S_I_RD   = 4'd3;   // insert: read entry j
   localparam logic [3:0] S_I_CMP  = 4'd4;   // insert: compare entry j
   localparam logic [3:0] S_I_SH   = 4'd5;   // insert: decide on shift
   localparam logic [3:0] S_S_RD   = 4'd6;   // shift: read entry k-1
   localparam logic [3:0] S_S_WR   = 4'd7;   // shift: write it to k
   localparam logic [3:0] S_P_LIST = 4'd8;   // prune: next list
   localparam logic [3:0] S_P_RD   = 4'd9;   // prune: read entry j
   localparam logic [3:0] S_P_CMP  = 4'd10;  // prune: keep or drop entry j
   localparam logic [3:0] S_P_EMIT = 4'd11;  // prune: report emptied list
   localparam logic [3:0] S_P_DONE = 4'd12;  // prune: done with count
   localparam logic [3:0] S_B_LIST = 4'd13;  // best: next list head
   localparam logic [3:0] S_B_CMP  = 4'd14;  // best: compare head
   localparam logic [3:0] S_B_DONE = 4'd15;  // best: report

   // configuration registers
   logic                             mode_ff;
   logic [tkc_pkg::CSIZE_W-1:0]      csize_ff;
   logic [tkc_pkg::INDEX_W-1:0]      start_ff;
   logic signed [MW-1:0]             invalid_ff;

   // sequencer and operand registers
   logic [3:0]                state_ff, state_in;
   logic [LI_W-1:0]           i_ff, i_in;
   logic [LEN_W-1:0]          j_ff, j_in;
   logic [LEN_W-1:0]          w_ff, w_in;
   logic [LEN_W-1:0]          k_ff, k_in;
   logic [LEN_W-1:0]          pos_ff, pos_in;
   logic [LEN_W-1:0]          newlen_ff, newlen_in;
   logic [LEN_W-1:0]          lenc_ff, lenc_in;
   logic [LIST_BITS-1:0]      idx_ff, idx_in;
   logic                      inrange_ff, inrange_in;
   logic [NODE_BITS-1:0]      nb_ff, nb_in;
   logic signed [MW-1:0]      m_ff, m_in;
   logic signed [MW-1:0]      best_ff, best_in;
   logic                      found_ff, found_in;
   logic [tkc_pkg::INDEX_W-1:0] src_ff, src_in;
   logic [tkc_pkg::INDEX_W-1:0] dst_ff, dst_in;
   logic [tkc_pkg::COUNT_W-1:0] cnt_ff, cnt_in;

   // list lengths, cleared by reset
   logic [LEN_W-1:0]          len_ff [NUM_OWNED];
   logic                      len_we;
   logic [LIST_BITS-1:0]      len_wa;
   logic [LEN_W-1:0]          len_wd;

   // response register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tkc_pkg::KIND_W-1:0]  rsp_kind_ff, rsp_kind_in;
   logic [tkc_pkg::INDEX_W-1:0] rsp_list_ff, rsp_list_in;
   logic [tkc_pkg::COUNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic                        rsp_found_ff, rsp_found_in;
   logic [tkc_pkg::INDEX_W-1:0] rsp_src_ff, rsp_src_in;
   logic [tkc_pkg::INDEX_W-1:0] rsp_dst_ff, rsp_dst_in;
   logic signed [MW-1:0]        rsp_metric_ff, rsp_metric_in;
   logic                        rsp_last_ff, rsp_last_in;

   // entry ram ports
   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_wa;
   logic [ENTRY_W-1:0]   ram_wd;
   logic [ADDR_W-1:0]    ram_ra;
   logic [ENTRY_W-1:0]   ram_rd;
   logic [NODE_BITS-1:0] rd_nb;
   logic signed [MW-1:0] rd_m;

   // shared compare unit
   logic signed [MW-1:0] cmp_b;
   logic                 rd_better;

   logic                 req_fire;
   logic                 rsp_free;
   logic [LEN_W-1:0]     cap;
   logic [LEN_W-1:0]     len_cur;
   logic [LEN_W-1:0]     len_idx;
   logic [tkc_pkg::INDEX_W:0] owner_diff;
   logic [tkc_pkg::INDEX_W-1:0] list_gidx;

   tkc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign rd_nb = ram_rd[ENTRY_W-1:MW];
   assign rd_m  = ram_rd[MW-1:0];

   // best query compares against the running best, insert against the new metric
   assign cmp_b = (state_ff == S_B_CMP) ? best_ff : m_ff;

   tkc_better u_better (
      .mode     (mode_ff),
      .a        (rd_m),
      .b        (cmp_b),
      .a_better (rd_better)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // capacity saturated to the list depth
   assign cap = ({4'd0, csize_ff} > 8'(MAX_ENTRIES)) ? LEN_W'(MAX_ENTRIES)
                                                     : LEN_W'(csize_ff);
   assign len_cur = len_ff[LIST_BITS'(i_ff)];
   assign len_idx = len_ff[idx_ff];
   assign owner_diff = {1'b0, req_ch.owner_index} - {1'b0, start_ff};
   assign list_gidx  = start_ff + tkc_pkg::INDEX_W'(i_ff);

   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      w_in       = w_ff;
      k_in       = k_ff;
      pos_in     = pos_ff;
      newlen_in  = newlen_ff;
      lenc_in    = lenc_ff;
      idx_in     = idx_ff;
      inrange_in = inrange_ff;
      nb_in      = nb_ff;
      m_in       = m_ff;
      best_in    = best_ff;
      found_in   = found_ff;
      src_in     = src_ff;
      dst_in     = dst_ff;
      cnt_in     = cnt_ff;
      len_we     = 1'b0;
      len_wa     = idx_ff;
      len_wd     = newlen_ff;
      ram_we     = 1'b0;
      ram_wa     = {idx_ff, SLOT_BITS'(pos_ff)};
      ram_wd     = {nb_ff, m_ff};
      ram_ra     = {idx_ff, SLOT_BITS'(j_ff)};

      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_list_in   = rsp_list_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_src_in    = rsp_src_ff;
      rsp_dst_in    = rsp_dst_ff;
      rsp_metric_in = rsp_metric_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               nb_in      = NODE_BITS'(req_ch.node_index);
               m_in       = req_ch.metric_in;
               idx_in     = LIST_BITS'(owner_diff);
               inrange_in = !owner_diff[tkc_pkg::INDEX_W] &&
                            (owner_diff[tkc_pkg::INDEX_W-1:0] <
                             tkc_pkg::INDEX_W'(NUM_OWNED));
               i_in       = '0;
               cnt_in     = '0;
               best_in    = invalid_ff;
               found_in   = 1'b0;
               src_in     = tkc_pkg::NO_INDEX;
               dst_in     = tkc_pkg::NO_INDEX;
               unique case (req_ch.func)
                  tkc_pkg::FUNC_INSERT: state_in = S_I_CHK;
                  tkc_pkg::FUNC_PRUNE:  state_in = S_P_LIST;
                  tkc_pkg::FUNC_BEST:   state_in = S_B_LIST;
                  default:              state_in = S_IDLE;
               endcase
            end
         end
         S_I_CHK: begin
            lenc_in   = len_idx;
            newlen_in = (len_idx >= cap) ? cap : len_idx + LEN_W'(1);
            j_in      = '0;
            if (!inrange_ff || cap == '0) begin
               state_in = S_IDLE;
            end else if (len_idx >= cap && len_idx != '0) begin
               ram_ra   = {idx_ff, SLOT_BITS'(len_idx - LEN_W'(1))};
               state_in = S_I_CHKW;
            end else begin
               state_in = S_I_RD;
            end
         end
         S_I_CHKW: begin
            // worst entry strictly better drops the insert
            state_in = rd_better ? S_IDLE : S_I_RD;
         end
         S_I_RD: begin
            if (j_ff < lenc_ff) begin
               state_in = S_I_CMP;
            end else begin
               pos_in   = j_ff;
               state_in = S_I_SH;
            end
         end
         S_I_CMP: begin
            if (rd_better) begin
               j_in     = j_ff + LEN_W'(1);
               state_in = S_I_RD;
            end else begin
               pos_in   = j_ff;
               state_in = S_I_SH;
            end
         end
         S_I_SH: begin
            k_in     = newlen_ff - LEN_W'(1);
            state_in = (pos_ff >= newlen_ff) ? S_IDLE : S_S_RD;
         end
         S_S_RD: begin
            ram_ra = {idx_ff, SLOT_BITS'(k_ff - LEN_W'(1))};
            if (k_ff > pos_ff) begin
               state_in = S_S_WR;
            end else begin
               ram_we   = 1'b1;
               len_we   = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_S_WR: begin
            ram_we   = 1'b1;
            ram_wa   = {idx_ff, SLOT_BITS'(k_ff)};
            ram_wd   = ram_rd;
            k_in     = k_ff - LEN_W'(1);
            state_in = S_S_RD;
         end
         S_P_LIST: begin
            j_in = '0;
            w_in = '0;
            if (i_ff == LI_W'(NUM_OWNED)) begin
               state_in = S_P_DONE;
            end else if (len_cur == '0) begin
               i_in = i_ff + LI_W'(1);
            end else begin
               state_in = S_P_RD;
            end
         end
         S_P_RD: begin
            ram_ra = {LIST_BITS'(i_ff), SLOT_BITS'(j_ff)};
            if (j_ff < len_cur) begin
               state_in = S_P_CMP;
            end else begin
               len_we = 1'b1;
               len_wa = LIST_BITS'(i_ff);
               len_wd = w_ff;
               if (w_ff == '0) begin
                  state_in = S_P_EMIT;
               end else begin
                  i_in     = i_ff + LI_W'(1);
                  state_in = S_P_LIST;
               end
            end
         end
         S_P_CMP: begin
            // compact kept entries toward the head
            if (rd_nb != nb_ff) begin
               ram_we = 1'b1;
               ram_wa = {LIST_BITS'(i_ff), SLOT_BITS'(w_ff)};
               ram_wd = ram_rd;
               w_in   = w_ff + LEN_W'(1);
            end
            j_in     = j_ff + LEN_W'(1);
            state_in = S_P_RD;
         end
         S_P_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = tkc_pkg::KIND_EMPTIED;
               rsp_list_in   = list_gidx;
               rsp_cnt_in    = '0;
               rsp_found_in  = 1'b0;
               rsp_src_in    = '0;
               rsp_dst_in    = '0;
               rsp_metric_in = '0;
               rsp_last_in   = 1'b0;
               cnt_in        = cnt_ff + tkc_pkg::COUNT_W'(1);
               i_in          = i_ff + LI_W'(1);
               state_in      = S_P_LIST;
            end
         end
         S_P_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = tkc_pkg::KIND_DONE;
               rsp_list_in   = '0;
               rsp_cnt_in    = cnt_ff;
               rsp_found_in  = 1'b0;
               rsp_src_in    = '0;
               rsp_dst_in    = '0;
               rsp_metric_in = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_B_LIST: begin
            ram_ra = {LIST_BITS'(i_ff), SLOT_BITS'(0)};
            if (i_ff == LI_W'(NUM_OWNED)) begin
               state_in = S_B_DONE;
            end else if (len_cur == '0) begin
               i_in = i_ff + LI_W'(1);
            end else begin
               state_in = S_B_CMP;
            end
         end
         S_B_CMP: begin
            if (rd_better) begin
               found_in = 1'b1;
               best_in  = rd_m;
               src_in   = list_gidx;
               dst_in   = tkc_pkg::INDEX_W'(rd_nb);
            end
            i_in     = i_ff + LI_W'(1);
            state_in = S_B_LIST;
         end
         S_B_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = tkc_pkg::KIND_BEST;
               rsp_list_in   = '0;
               rsp_cnt_in    = '0;
               rsp_found_in  = found_ff;
               rsp_src_in    = src_ff;
               rsp_dst_in    = dst_ff;
               rsp_metric_in = best_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= tkc_pkg::METRIC_MODE_RST;
         csize_ff   <= tkc_pkg::CACHE_SIZE_RST;
         start_ff   <= tkc_pkg::START_INDEX_RST;
         invalid_ff <= tkc_pkg::INVALID_METRIC_RST;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            tkc_pkg::CSR_METRIC_MODE:    mode_ff    <= csr_ch.data[0];
            tkc_pkg::CSR_CACHE_SIZE:     csize_ff   <= csr_ch.data[tkc_pkg::CSIZE_W-1:0];
            tkc_pkg::CSR_START_INDEX:    start_ff   <= csr_ch.data[tkc_pkg::INDEX_W-1:0];
            tkc_pkg::CSR_INVALID_METRIC: invalid_ff <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int n = 0; n < NUM_OWNED; n++) begin
            len_ff[n] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (len_we) begin
            len_ff[len_wa] <= len_wd;
         end
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      j_ff          <= j_in;
      w_ff          <= w_in;
      k_ff          <= k_in;
      pos_ff        <= pos_in;
      newlen_ff     <= newlen_in;
      lenc_ff       <= lenc_in;
      idx_ff        <= idx_in;
      inrange_ff    <= inrange_in;
      nb_ff         <= nb_in;
      m_ff          <= m_in;
      best_ff       <= best_in;
      found_ff      <= found_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      cnt_ff        <= cnt_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_list_ff   <= rsp_list_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_src_ff    <= rsp_src_in;
      rsp_dst_ff    <= rsp_dst_in;
      rsp_metric_ff <= rsp_metric_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.kind          = rsp_kind_ff;
   assign rsp_ch.list_index    = rsp_list_ff;
   assign rsp_ch.emptied_count = rsp_cnt_ff;
   assign rsp_ch.found         = rsp_found_ff;
   assign rsp_ch.source_index  = rsp_src_ff;
   assign rsp_ch.dest_index    = rsp_dst_ff;
   assign rsp_ch.metric_out    = rsp_metric_ff;
   assign rsp_ch.last          = rsp_last_ff;

   // a best entry is always the single, final response of its query
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff == tkc_pkg::KIND_BEST) |-> rsp_last_ff)
      else $error("best response without last");

   // an accepted request that does work leaves idle
   assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_ch.func != tkc_pkg::FUNC_NONE) |=> (state_ff != S_IDLE))
      else $error("request accepted but sequencer stayed idle");

   // a list never grows past its depth
   assert property (@(posedge clock) disable iff (reset)
      len_we |-> (len_wd <= LEN_W'(MAX_ENTRIES)))
      else $error("list length beyond depth");

   // ram writes only come from shift or compaction steps
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_S_RD || state_ff == S_S_WR || state_ff == S_P_CMP))
      else $error("entry ram written outside a write step");

endmodule

`default_nettype wire

### verif/tkc_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkc_tb_pkg
// transaction types shared by the cache testbench
// ----------------------------------------------------------------------------
package tkc_tb_pkg;

   typedef struct packed {
      logic [tkc_pkg::FUNC_W-1:0]          func;
      logic [tkc_pkg::INDEX_W-1:0]         owner_index;
      logic [tkc_pkg::INDEX_W-1:0]         node_index;
      logic signed [tkc_pkg::METRIC_W-1:0] metric_in;
   } cache_req_type;

   typedef struct packed {
      logic [tkc_pkg::KIND_W-1:0]          kind;
      logic [tkc_pkg::INDEX_W-1:0]         list_index;
      logic [tkc_pkg::COUNT_W-1:0]         emptied_count;
      logic                                found;
      logic [tkc_pkg::INDEX_W-1:0]         source_index;
      logic [tkc_pkg::INDEX_W-1:0]         dest_index;
      logic signed [tkc_pkg::METRIC_W-1:0] metric_out;
      logic                                last;
   } cache_rsp_type;
endpackage

### verif/topk_neighbor_cache_for_mst_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topk_neighbor_cache_for_mst_tb
// drives inserts, prunes and best queries through several register settings
// and checks every response against a behavioral copy of the candidate lists
// ----------------------------------------------------------------------------
module topk_neighbor_cache_for_mst_tb;

   localparam int NOWN = tkc_pkg::NUM_OWNED_DEF;
   localparam int NENT = tkc_pkg::MAX_ENTRIES_DEF;
   localparam int MW   = tkc_pkg::METRIC_W;
   localparam int IW   = tkc_pkg::INDEX_W;
   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_CYCLES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   tkc_req_if req_ch ();
   tkc_rsp_if rsp_ch ();
   tkc_csr_if csr_ch ();

   topk_neighbor_cache_for_mst uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // shadow of the registers and the lists
   logic                         mode_q;
   logic [tkc_pkg::CSIZE_W-1:0]  csize_q;
   logic [IW-1:0]                start_q;
   logic signed [MW-1:0]         invalid_q;
   logic [IW-1:0]                nb_mem [NOWN][NENT];
   logic signed [MW-1:0]         met_mem [NOWN][NENT];
   int                           len_mem [NOWN];

   tkc_tb_pkg::cache_req_type pending_reqs[$];
   tkc_tb_pkg::cache_rsp_type expected_rsps[$];

   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_ask = 0;     // bumped to request a long receiver hold
   int hold_seen = 0;
   int hold_rsp = 0;     // cycles the receiver still refuses
   bit gate_send = 1'b0; // sender paused while responses are still expected
   int quiet_cycles = 0;
   int accepted_n = 0;   // requests accepted so far
   int offer_n = 0;      // count that marks the current offer as taken

   function automatic bit is_better(logic signed [MW-1:0] a, logic signed [MW-1:0] b);
      return mode_q ? (a < b) : (a > b);
   endfunction

   function automatic void expect_rsp(tkc_tb_pkg::cache_rsp_type e);
      expected_rsps.insert(expected_rsps.size(), e);
   endfunction

   // apply one request to the shadow lists, queue what it must return
   function automatic void predict_cache(tkc_tb_pkg::cache_req_type r);
      int idx, cap, len, pos, nlen, w, k;
      tkc_tb_pkg::cache_rsp_type e;
      logic [16:0] off;
      logic signed [MW-1:0] best;
      idx = 0;
      case (r.func)
         tkc_pkg::FUNC_INSERT: begin
            off = {1'b0, r.owner_index} - {1'b0, start_q};
            if (r.owner_index < start_q || off >= NOWN) return;
            idx = off;
            cap = (csize_q > NENT) ? NENT : csize_q;
            len = len_mem[idx];
            if (len >= cap && len > 0 && is_better(met_mem[idx][len-1], r.metric_in))
               return;
            if (cap == 0) return;
            pos = 0;
            while (pos < len && is_better(met_mem[idx][pos], r.metric_in)) pos++;
            nlen = (len + 1 > cap) ? cap : len + 1;
            if (pos >= nlen) return;
            for (int j = nlen - 1; j > pos; j--) begin
               nb_mem[idx][j]  = nb_mem[idx][j-1];
               met_mem[idx][j] = met_mem[idx][j-1];
            end
            nb_mem[idx][pos]  = r.node_index;
            met_mem[idx][pos] = r.metric_in;
            len_mem[idx] = nlen;
         end
         tkc_pkg::FUNC_PRUNE: begin
            k = 0;
            for (int i = 0; i < NOWN; i++) begin
               if (len_mem[i] == 0) continue;
               w = 0;
               for (int j = 0; j < len_mem[i]; j++) begin
                  if (nb_mem[i][j] != r.node_index) begin
                     nb_mem[i][w]  = nb_mem[i][j];
                     met_mem[i][w] = met_mem[i][j];
                     w++;
                  end
               end
               len_mem[i] = w;
               if (w == 0) begin
                  e = '0;
                  e.kind = tkc_pkg::KIND_EMPTIED;
                  e.list_index = start_q + IW'(i);
                  expect_rsp(e);
                  k++;
               end
            end
            e = '0;
            e.kind = tkc_pkg::KIND_DONE;
            e.emptied_count = tkc_pkg::COUNT_W'(k);
            e.last = 1'b1;
            expect_rsp(e);
         end
         tkc_pkg::FUNC_BEST: begin
            e = '0;
            e.kind = tkc_pkg::KIND_BEST;
            e.source_index = tkc_pkg::NO_INDEX;
            e.dest_index = tkc_pkg::NO_INDEX;
            best = invalid_q;
            for (int i = 0; i < NOWN; i++) begin
               if (len_mem[i] == 0) continue;
               if (is_better(met_mem[i][0], best)) begin
                  e.found = 1'b1;
                  e.source_index = start_q + IW'(i);
                  e.dest_index = nb_mem[i][0];
                  best = met_mem[i][0];
               end
            end
            e.metric_out = best;
            e.last = 1'b1;
            expect_rsp(e);
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("error: %s got %0h expected %0h at %0t", what, got, want, $realtime);
   endtask

   // driver: feeds pending items at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid       <= 1'b0;
         req_ch.func        <= tkc_pkg::FUNC_NONE;
         req_ch.owner_index <= '0;
         req_ch.node_index  <= '0;
         req_ch.metric_in   <= '0;
      end else if (req_ch.valid && accepted_n != offer_n) begin
         // hold the offer until it is taken
      end else if (pending_reqs.size() > 0 && !(gate_send && expected_rsps.size() > 0)
                   && $urandom_range(99) >= send_idle_pct) begin
         req_ch.valid       <= 1'b1;
         req_ch.func        <= pending_reqs[0].func;
         req_ch.owner_index <= pending_reqs[0].owner_index;
         req_ch.node_index  <= pending_reqs[0].node_index;
         req_ch.metric_in   <= pending_reqs[0].metric_in;
         offer_n            <= accepted_n + 1;
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // pop on acceptance, predict at once
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         predict_cache(pending_reqs.pop_front());
         accepted_n <= accepted_n + 1;
      end
   end

   // receiver ready at the falling edge, with a long hold when asked
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_ask != hold_seen) begin
         hold_seen <= hold_ask;
         hold_rsp <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_rsp > 0) begin
         hold_rsp <= hold_rsp - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      tkc_tb_pkg::cache_rsp_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response kind", rsp_ch.kind, 0);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_ch.kind !== e.kind) report_mismatch("kind", rsp_ch.kind, e.kind);
            if (rsp_ch.list_index !== e.list_index)
               report_mismatch("list_index", rsp_ch.list_index, e.list_index);
            if (rsp_ch.emptied_count !== e.emptied_count)
               report_mismatch("emptied_count", rsp_ch.emptied_count, e.emptied_count);
            if (rsp_ch.found !== e.found) report_mismatch("found", rsp_ch.found, e.found);
            if (rsp_ch.source_index !== e.source_index)
               report_mismatch("source_index", rsp_ch.source_index, e.source_index);
            if (rsp_ch.dest_index !== e.dest_index)
               report_mismatch("dest_index", rsp_ch.dest_index, e.dest_index);
            if (rsp_ch.metric_out !== e.metric_out)
               report_mismatch("metric_out", rsp_ch.metric_out, e.metric_out);
            if (rsp_ch.last !== e.last) report_mismatch("last", rsp_ch.last, e.last);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("topk_neighbor_cache_for_mst: mismatch");
            $finish;
         end
      end
   end

   function automatic tkc_tb_pkg::cache_req_type make_req(logic [tkc_pkg::FUNC_W-1:0] f,
                                                          int owner, int node,
                                                          logic signed [MW-1:0] m);
      tkc_tb_pkg::cache_req_type r;
      r.func = f;
      r.owner_index = IW'(owner);
      r.node_index = IW'(node);
      r.metric_in = m;
      return r;
   endfunction

   function automatic void queue_req(tkc_tb_pkg::cache_req_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endfunction

   // well-formed mix: mostly in-range inserts over a small node pool
   task automatic queue_random(int count);
      int sel, owner, node;
      logic signed [MW-1:0] m;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(99);
         owner = (start_q + $urandom_range(NOWN - 1)) & 16'hffff;
         node = $urandom_range(15);
         if ($urandom_range(9) == 0) node = $urandom;
         if ($urandom_range(3) == 0) m = $signed($urandom);
         else m = $signed(32'($urandom_range(40))) - 20;
         if (sel < 60) begin
            if ($urandom_range(19) == 0) owner = $urandom;
            queue_req(make_req(tkc_pkg::FUNC_INSERT, owner, node, m));
         end else if (sel < 78) begin
            queue_req(make_req(tkc_pkg::FUNC_PRUNE, owner, node, m));
         end else if (sel < 96) begin
            queue_req(make_req(tkc_pkg::FUNC_BEST, owner, node, m));
         end else begin
            queue_req(make_req(tkc_pkg::FUNC_NONE, owner, node, m));
         end
      end
   endtask

   task automatic drain_all();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_ch.valid)
         @(posedge clock);
      // inserts leave no response, let the last one finish
      repeat (4 * NENT + 16) @(posedge clock);
   endtask

   // one register write at the falling edge, waits for the handshake
   task automatic write_csr(logic [tkc_pkg::CSR_IDX_W-1:0] idx,
                            logic [tkc_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         tkc_pkg::CSR_METRIC_MODE:    mode_q = val[0];
         tkc_pkg::CSR_CACHE_SIZE:     csize_q = val[tkc_pkg::CSIZE_W-1:0];
         tkc_pkg::CSR_START_INDEX:    start_q = val[IW-1:0];
         tkc_pkg::CSR_INVALID_METRIC: invalid_q = $signed(val);
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      mode_q = tkc_pkg::METRIC_MODE_RST;
      csize_q = tkc_pkg::CACHE_SIZE_RST;
      start_q = tkc_pkg::START_INDEX_RST;
      invalid_q = tkc_pkg::INVALID_METRIC_RST;
      for (int i = 0; i < NOWN; i++) len_mem[i] = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, ties, full list, emptied reports, unused func
      send_idle_pct = 27;
      recv_idle_pct = 59;
      queue_req(make_req(tkc_pkg::FUNC_BEST, 0, 0, 0));
      queue_req(make_req(tkc_pkg::FUNC_PRUNE, 0, 0, 0));
      queue_req(make_req(tkc_pkg::FUNC_INSERT, 0, 16'hffff, 32'sh7fffffff));
      queue_req(make_req(tkc_pkg::FUNC_INSERT, 31, 0, 32'sh80000000));
      queue_req(make_req(tkc_pkg::FUNC_INSERT, 32, 5, 100));
      queue_req(make_req(tkc_pkg::FUNC_INSERT, 16'hffff, 5, 100));
      for (int j = 0; j < 10; j++)
         queue_req(make_req(tkc_pkg::FUNC_INSERT, 3, j + 1, (j % 3) * 65536));
      queue_req(make_req(tkc_pkg::FUNC_INSERT, 3, 12, 32'sh80000000));
      queue_req(make_req(tkc_pkg::FUNC_BEST, 0, 0, 0));
      queue_req(make_req(tkc_pkg::FUNC_NONE, 16'hffff, 16'hffff, -1));
      queue_req(make_req(tkc_pkg::FUNC_PRUNE, 0, 16'hffff, 0));
      queue_req(make_req(tkc_pkg::FUNC_PRUNE, 0, 0, 0));
      queue_req(make_req(tkc_pkg::FUNC_BEST, 0, 0, 0));
      queue_random(30);
      // long receiver hold while items keep coming
      while (pending_reqs.size() > 20) @(posedge clock);
      hold_ask = hold_ask + 1;
      drain_all();

      // distance mode, small capacity, high start, positive invalid
      write_csr(tkc_pkg::CSR_METRIC_MODE, 32'd1);
      write_csr(tkc_pkg::CSR_CACHE_SIZE, 32'd1);
      write_csr(tkc_pkg::CSR_START_INDEX, 32'hffe8);
      write_csr(tkc_pkg::CSR_INVALID_METRIC, 32'h7fffffff);
      send_idle_pct = 59;
      recv_idle_pct = 27;
      queue_req(make_req(tkc_pkg::FUNC_INSERT, 16'hffe7, 1, 0));
      queue_req(make_req(tkc_pkg::FUNC_INSERT, 16'hfff0, 9, 5));
      queue_req(make_req(tkc_pkg::FUNC_INSERT, 16'h0007, 9, 5));
      queue_random(40);
      drain_all();

      // sender pauses until everything has returned
      gate_send = 1'b1;
      write_csr(tkc_pkg::CSR_CACHE_SIZE, 32'd15);
      write_csr(tkc_pkg::CSR_START_INDEX, 32'd100);
      write_csr(tkc_pkg::CSR_INVALID_METRIC, 32'h80000000);
      queue_random(10);
      drain_all();
      gate_send = 1'b0;

      // back to similarity, zero capacity then mid capacity, no idling
      write_csr(tkc_pkg::CSR_METRIC_MODE, 32'd0);
      write_csr(tkc_pkg::CSR_CACHE_SIZE, 32'd0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(10);
      drain_all();
      write_csr(tkc_pkg::CSR_CACHE_SIZE, 32'd3);
      write_csr(tkc_pkg::CSR_INVALID_METRIC, 32'hffff0000);
      queue_random(60);
      drain_all();

      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("topk_neighbor_cache_for_mst: match");
      end else begin
         $display("topk_neighbor_cache_for_mst: mismatch");
      end
      $finish;
   end
endmodule

### topk_neighbor_cache_for_mst.f
rtl/tkc_pkg.sv
rtl/tkc_if.sv
rtl/tkc_ram.sv
rtl/tkc_better.sv
rtl/topk_neighbor_cache_for_mst.sv
verif/tkc_tb_pkg.sv
verif/topk_neighbor_cache_for_mst_tb.sv
